[rtl/core/modbus_rtu_register_slave_defines.svh]
// ----------------------------------------------------------------------------
// modbus_rtu_register_slave_defines.svh
// Assertion macros used by the modbus slave top level
// ----------------------------------------------------------------------------
`ifndef MODBUS_RTU_REGISTER_SLAVE_DEFINES_SVH
`define MODBUS_RTU_REGISTER_SLAVE_DEFINES_SVH

// same-cycle implication, off during reset
`define MBRS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mbrs assertion failed");

// next-cycle implication, off during reset
`define MBRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mbrs assertion failed");

`endif

[rtl/core/mbrs_pkg.sv]
// ----------------------------------------------------------------------------
// mbrs_pkg
// Types, constants and control/status bundles of the modbus register slave
// ----------------------------------------------------------------------------
`default_nettype none

package mbrs_pkg;

  localparam int FRAME_BYTES_DEF = 256;
  localparam int REG_WORDS_DEF   = 64;
  localparam int STORE_DEPTH     = 256;
  localparam int STORE_AW        = 8;
  localparam int CFG_IW          = 2;

  localparam logic [15:0] CRC_POLY_REFL = 16'hA001;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] QTY_MAX       = 16'h007D;
  localparam logic [7:0]  EXC_FLAG      = 8'h80;
  localparam logic [7:0]  EXC_FUNCTION  = 8'h01;
  localparam logic [7:0]  EXC_ADDRESS   = 8'h02;
  localparam logic [7:0]  EXC_VALUE     = 8'h03;
  localparam logic [8:0]  MIN_FRAME     = 9'd4;

  localparam logic [7:0] SLAVE_ADDR_RST = 8'd1;
  localparam logic [6:0] MAP_WORDS_RST  = 7'd64;

  // command codes
  localparam logic [2:0] CMD_RX      = 3'd0;
  localparam logic [2:0] CMD_END     = 3'd1;
  localparam logic [2:0] CMD_FETCH   = 3'd2;
  localparam logic [2:0] CMD_HOST_RD = 3'd3;
  localparam logic [2:0] CMD_HOST_WR = 3'd4;

  // frame status codes
  localparam logic [2:0] ST_NONE       = 3'd0;
  localparam logic [2:0] ST_READY      = 3'd1;
  localparam logic [2:0] ST_BAD_CRC    = 3'd2;
  localparam logic [2:0] ST_OTHER_ADDR = 3'd3;
  localparam logic [2:0] ST_SHORT      = 3'd4;

  // function codes
  localparam logic [7:0] FN_READ_HOLD  = 8'd3;
  localparam logic [7:0] FN_READ_INPUT = 8'd4;
  localparam logic [7:0] FN_WRITE_ONE  = 8'd6;
  localparam logic [7:0] FN_WRITE_MANY = 8'd16;

  // configuration register indexes
  localparam logic [CFG_IW-1:0] CFG_SLAVE_ADDR = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_MAP_WORDS  = 2'd1;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  rx_data;
    logic [6:0]  host_index;
    logic [15:0] host_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  frame_status;
    logic [7:0]  reply_length;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic [15:0] host_read_value;
  } out_item_t;

  typedef enum logic [1:0] {
    SA_PTR   = 2'd0,
    SA_COUNT = 2'd1,
    SA_POS   = 2'd2
  } store_addr_sel_t;

  typedef enum logic [2:0] {
    WD_RX       = 3'd0,
    WD_EXC_FUNC = 3'd1,
    WD_EXC_CODE = 3'd2,
    WD_QTY2     = 3'd3,
    WD_MAP_HI   = 3'd4,
    WD_MAP_LO   = 3'd5,
    WD_CRC_LO   = 3'd6,
    WD_CRC_HI   = 3'd7
  } store_wd_sel_t;

  typedef enum logic [1:0] {
    PTR_HOLD = 2'd0,
    PTR_INC  = 2'd1,
    PTR_LD   = 2'd2
  } ptr_op_t;

  typedef enum logic [2:0] {
    CRC_HOLD   = 3'd0,
    CRC_SEED   = 3'd1,
    CRC_XOR_RX = 3'd2,
    CRC_XOR_RD = 3'd3,
    CRC_STEP   = 3'd4
  } crc_op_t;

  typedef enum logic [1:0] {
    MW_NONE   = 2'd0,
    MW_HOST   = 2'd1,
    MW_SINGLE = 2'd2,
    MW_MULTI  = 2'd3
  } map_wr_t;

  typedef enum logic [1:0] {
    MR_NONE = 2'd0,
    MR_HOST = 2'd1,
    MR_LOOP = 2'd2
  } map_rd_t;

  typedef enum logic [1:0] {
    LEN_HOLD  = 2'd0,
    LEN_EXC   = 2'd1,
    LEN_WRITE = 2'd2,
    LEN_READ  = 2'd3
  } len_sel_t;

  typedef struct packed {
    logic            accept;
    logic            store_we;
    logic            store_re;
    store_addr_sel_t addr_sel;
    store_wd_sel_t   wd_sel;
    ptr_op_t         ptr_op;
    logic [7:0]      ptr_val;
    crc_op_t         crc_op;
    map_wr_t         map_wr;
    map_rd_t         map_rd;
    len_sel_t        len_sel;
    logic            cnt_inc;
    logic            frame_clr;
    logic            hdr_cap;
    logic            hi_cap;
    logic            i_clr;
    logic            i_inc;
    logic            exc_ld;
    logic [7:0]      exc_code;
    logic            res_clr;
    logic            status_ld;
    logic [2:0]      status;
    logic            res_fetch;
    logic            res_host;
    logic            reply_start;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       pending;
    logic       rx_room;
    logic       short_frame;
    logic       crc_bad;
    logic       host_in_range;
    logic       addr_match;
    logic [7:0] func;
    logic       qty_bad;
    logic       range_bad;
    logic       single_bad;
    logic       bc_bad;
    logic       hdr_done;
    logic       bit_last;
    logic       loop_last;
    logic       seal_done;
  } dp_stat_t;

endpackage

`default_nettype wire

[rtl/core/mbrs_ctrl.sv]
// ----------------------------------------------------------------------------
// mbrs_ctrl
// Sequencer of the modbus slave: command dispatch, frame checks, serve steps
// ----------------------------------------------------------------------------
`default_nettype none

module mbrs_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  mbrs_pkg::dp_stat_t      stat,
  output mbrs_pkg::ctrl_cmd_t     cmd,
  output logic                    busy,
  output logic                    out_valid
);

  typedef enum logic [23:0] {
    S_IDLE      = 24'h000001,
    S_DISP      = 24'h000002,
    S_CRC_RX    = 24'h000004,
    S_FETCH     = 24'h000008,
    S_HRD       = 24'h000010,
    S_HDR_RD    = 24'h000020,
    S_HDR_CAP   = 24'h000040,
    S_CHECK     = 24'h000080,
    S_EXC1      = 24'h000100,
    S_EXC2      = 24'h000200,
    S_RQ        = 24'h000400,
    S_RMAP      = 24'h000800,
    S_RHI       = 24'h001000,
    S_RLO       = 24'h002000,
    S_WRD       = 24'h004000,
    S_WHI       = 24'h008000,
    S_WLO       = 24'h010000,
    S_SEAL_INIT = 24'h020000,
    S_SEAL_RD   = 24'h040000,
    S_SEAL_LD   = 24'h080000,
    S_SEAL_BIT  = 24'h100000,
    S_SEAL_WLO  = 24'h200000,
    S_SEAL_WHI  = 24'h400000,
    S_DONE      = 24'h800000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

  always_comb begin
    logic       go_exc;
    logic [7:0] exc_code;
    cmd       = '0;
    state_nxt = state_r;
    go_exc    = 1'b0;
    exc_code  = mbrs_pkg::EXC_FUNCTION;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DISP;
        end
      end
      S_DISP: begin
        cmd.res_clr = 1'b1;
        state_nxt   = S_DONE;
        case (stat.cmd)
          mbrs_pkg::CMD_RX: begin
            if (!stat.pending && stat.rx_room) begin
              cmd.store_we = 1'b1;
              cmd.addr_sel = mbrs_pkg::SA_COUNT;
              cmd.wd_sel   = mbrs_pkg::WD_RX;
              cmd.cnt_inc  = 1'b1;
              cmd.crc_op   = mbrs_pkg::CRC_XOR_RX;
              state_nxt    = S_CRC_RX;
            end
          end
          mbrs_pkg::CMD_END: begin
            if (!stat.pending) begin
              cmd.frame_clr = 1'b1;
              if (stat.short_frame) begin
                cmd.status_ld = 1'b1;
                cmd.status    = mbrs_pkg::ST_SHORT;
              end else if (stat.crc_bad) begin
                cmd.status_ld = 1'b1;
                cmd.status    = mbrs_pkg::ST_BAD_CRC;
              end else begin
                cmd.ptr_op  = mbrs_pkg::PTR_LD;
                cmd.ptr_val = 8'd0;
                state_nxt   = S_HDR_RD;
              end
            end
          end
          mbrs_pkg::CMD_FETCH: begin
            if (stat.pending) begin
              cmd.store_re = 1'b1;
              cmd.addr_sel = mbrs_pkg::SA_POS;
              state_nxt    = S_FETCH;
            end
          end
          mbrs_pkg::CMD_HOST_RD: begin
            cmd.map_rd = mbrs_pkg::MR_HOST;
            state_nxt  = S_HRD;
          end
          mbrs_pkg::CMD_HOST_WR: begin
            if (stat.host_in_range) begin
              cmd.map_wr = mbrs_pkg::MW_HOST;
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_CRC_RX: begin
        cmd.crc_op = mbrs_pkg::CRC_STEP;
        if (stat.bit_last) begin
          state_nxt = S_DONE;
        end
      end
      S_FETCH: begin
        cmd.res_fetch = 1'b1;
        state_nxt     = S_DONE;
      end
      S_HRD: begin
        cmd.res_host = 1'b1;
        state_nxt    = S_DONE;
      end
      S_HDR_RD: begin
        cmd.store_re = 1'b1;
        state_nxt    = S_HDR_CAP;
      end
      S_HDR_CAP: begin
        cmd.hdr_cap = 1'b1;
        if (stat.hdr_done) begin
          state_nxt = S_CHECK;
        end else begin
          cmd.ptr_op = mbrs_pkg::PTR_INC;
          state_nxt  = S_HDR_RD;
        end
      end
      S_CHECK: begin
        if (!stat.addr_match) begin
          cmd.status_ld = 1'b1;
          cmd.status    = mbrs_pkg::ST_OTHER_ADDR;
          state_nxt     = S_DONE;
        end else begin
          case (stat.func) inside
            mbrs_pkg::FN_READ_HOLD, mbrs_pkg::FN_READ_INPUT: begin
              if (stat.qty_bad) begin
                go_exc   = 1'b1;
                exc_code = mbrs_pkg::EXC_VALUE;
              end else if (stat.range_bad) begin
                go_exc   = 1'b1;
                exc_code = mbrs_pkg::EXC_ADDRESS;
              end else begin
                cmd.ptr_op  = mbrs_pkg::PTR_LD;
                cmd.ptr_val = 8'd2;
                cmd.i_clr   = 1'b1;
                state_nxt   = S_RQ;
              end
            end
            mbrs_pkg::FN_WRITE_ONE: begin
              if (stat.single_bad) begin
                go_exc   = 1'b1;
                exc_code = mbrs_pkg::EXC_ADDRESS;
              end else begin
                cmd.map_wr  = mbrs_pkg::MW_SINGLE;
                cmd.len_sel = mbrs_pkg::LEN_WRITE;
                state_nxt   = S_SEAL_INIT;
              end
            end
            mbrs_pkg::FN_WRITE_MANY: begin
              if (stat.qty_bad || stat.bc_bad) begin
                go_exc   = 1'b1;
                exc_code = mbrs_pkg::EXC_VALUE;
              end else if (stat.range_bad) begin
                go_exc   = 1'b1;
                exc_code = mbrs_pkg::EXC_ADDRESS;
              end else begin
                cmd.ptr_op  = mbrs_pkg::PTR_LD;
                cmd.ptr_val = 8'd7;
                cmd.i_clr   = 1'b1;
                state_nxt   = S_WRD;
              end
            end
            default: begin
              go_exc   = 1'b1;
              exc_code = mbrs_pkg::EXC_FUNCTION;
            end
          endcase
          if (go_exc) begin
            cmd.exc_ld   = 1'b1;
            cmd.exc_code = exc_code;
            cmd.ptr_op   = mbrs_pkg::PTR_LD;
            cmd.ptr_val  = 8'd1;
            state_nxt    = S_EXC1;
          end
        end
      end
      S_EXC1: begin
        cmd.store_we = 1'b1;
        cmd.wd_sel   = mbrs_pkg::WD_EXC_FUNC;
        cmd.ptr_op   = mbrs_pkg::PTR_INC;
        state_nxt    = S_EXC2;
      end
      S_EXC2: begin
        cmd.store_we = 1'b1;
        cmd.wd_sel   = mbrs_pkg::WD_EXC_CODE;
        cmd.len_sel  = mbrs_pkg::LEN_EXC;
        state_nxt    = S_SEAL_INIT;
      end
      S_RQ: begin
        cmd.store_we = 1'b1;
        cmd.wd_sel   = mbrs_pkg::WD_QTY2;
        cmd.ptr_op   = mbrs_pkg::PTR_INC;
        state_nxt    = S_RMAP;
      end
      S_RMAP: begin
        cmd.map_rd = mbrs_pkg::MR_LOOP;
        state_nxt  = S_RHI;
      end
      S_RHI: begin
        cmd.store_we = 1'b1;
        cmd.wd_sel   = mbrs_pkg::WD_MAP_HI;
        cmd.ptr_op   = mbrs_pkg::PTR_INC;
        state_nxt    = S_RLO;
      end
      S_RLO: begin
        cmd.store_we = 1'b1;
        cmd.wd_sel   = mbrs_pkg::WD_MAP_LO;
        cmd.ptr_op   = mbrs_pkg::PTR_INC;
        cmd.i_inc    = 1'b1;
        if (stat.loop_last) begin
          cmd.len_sel = mbrs_pkg::LEN_READ;
          state_nxt   = S_SEAL_INIT;
        end else begin
          state_nxt = S_RMAP;
        end
      end
      S_WRD: begin
        cmd.store_re = 1'b1;
        cmd.ptr_op   = mbrs_pkg::PTR_INC;
        state_nxt    = S_WHI;
      end
      S_WHI: begin
        cmd.hi_cap   = 1'b1;
        cmd.store_re = 1'b1;
        cmd.ptr_op   = mbrs_pkg::PTR_INC;
        state_nxt    = S_WLO;
      end
      S_WLO: begin
        cmd.map_wr = mbrs_pkg::MW_MULTI;
        cmd.i_inc  = 1'b1;
        if (stat.loop_last) begin
          cmd.len_sel = mbrs_pkg::LEN_WRITE;
          state_nxt   = S_SEAL_INIT;
        end else begin
          state_nxt = S_WRD;
        end
      end
      S_SEAL_INIT: begin
        cmd.crc_op  = mbrs_pkg::CRC_SEED;
        cmd.ptr_op  = mbrs_pkg::PTR_LD;
        cmd.ptr_val = 8'd0;
        state_nxt   = S_SEAL_RD;
      end
      S_SEAL_RD: begin
        cmd.store_re = 1'b1;
        state_nxt    = S_SEAL_LD;
      end
      S_SEAL_LD: begin
        cmd.crc_op = mbrs_pkg::CRC_XOR_RD;
        cmd.ptr_op = mbrs_pkg::PTR_INC;
        state_nxt  = S_SEAL_BIT;
      end
      S_SEAL_BIT: begin
        cmd.crc_op = mbrs_pkg::CRC_STEP;
        if (stat.bit_last) begin
          state_nxt = stat.seal_done ? S_SEAL_WLO : S_SEAL_RD;
        end
      end
      S_SEAL_WLO: begin
        cmd.store_we = 1'b1;
        cmd.wd_sel   = mbrs_pkg::WD_CRC_LO;
        cmd.ptr_op   = mbrs_pkg::PTR_INC;
        state_nxt    = S_SEAL_WHI;
      end
      S_SEAL_WHI: begin
        cmd.store_we    = 1'b1;
        cmd.wd_sel      = mbrs_pkg::WD_CRC_HI;
        cmd.crc_op      = mbrs_pkg::CRC_SEED;
        cmd.reply_start = 1'b1;
        state_nxt       = S_DONE;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/mbrs_dp.sv]
// ----------------------------------------------------------------------------
// mbrs_dp
// Datapath: frame store, register map, bitwise crc, header and reply counters
// ----------------------------------------------------------------------------
`default_nettype none

module mbrs_dp #(
  parameter int FRAME_BYTES = mbrs_pkg::FRAME_BYTES_DEF,
  parameter int REG_WORDS   = mbrs_pkg::REG_WORDS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  mbrs_pkg::in_item_t                 in_data,
  input  wire logic                          cfg_valid,
  input  wire logic [mbrs_pkg::CFG_IW-1:0]   cfg_index,
  input  wire logic [7:0]                    cfg_data,
  input  mbrs_pkg::ctrl_cmd_t                cmd,
  output mbrs_pkg::dp_stat_t                 stat,
  output mbrs_pkg::out_item_t                out_data
);

  localparam int         MAP_AW    = (REG_WORDS > 1) ? $clog2(REG_WORDS) : 1;
  localparam logic [6:0] REG_LIM   = 7'(REG_WORDS);
  localparam logic [8:0] FRAME_LIM = 9'(FRAME_BYTES);

  mbrs_pkg::in_item_t  in_r;
  mbrs_pkg::out_item_t res_r, res_nxt;

  logic [7:0]  slave_r;
  logic [6:0]  mapw_r;
  logic [8:0]  count_r, count_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [2:0]  bit_r, bit_nxt;
  logic        pending_r, pending_nxt;
  logic [7:0]  total_r, total_nxt;
  logic [7:0]  pos_r, pos_nxt;
  logic [7:0]  ptr_r;
  logic [7:0]  len_r;
  logic [6:0]  i_r;
  logic [7:0]  exc_r;
  logic [7:0]  b0_r, func_r, b6_r, hi_r;
  logic [15:0] addr_r, qty_r;

  logic [7:0]  store_mem [mbrs_pkg::STORE_DEPTH];
  logic [7:0]  rd_q;
  logic [mbrs_pkg::STORE_AW-1:0] sa;
  logic [7:0]  wd;

  logic [15:0]          map_mem [REG_WORDS];
  logic [REG_WORDS-1:0] map_valid_r;
  logic [15:0]          map_q;
  logic                 map_vq;
  logic [15:0]          map_val;
  logic [MAP_AW-1:0]    map_wa, map_ra;
  logic [15:0]          map_wd;
  logic [7:0]           loop_idx;

  logic [6:0]  mw;
  logic        host_in_range;
  logic        fetch_last;
  logic [7:0]  reply_len;
  logic        frame_wipe;

  // ---- derived checks
  assign mw            = (mapw_r > REG_LIM) ? REG_LIM : mapw_r;
  assign host_in_range = (in_r.host_index < REG_LIM);
  assign fetch_last    = (({1'b0, pos_r} + 9'd1) >= {1'b0, total_r});
  assign reply_len     = len_r + 8'd2;
  assign loop_idx      = addr_r[7:0] + {1'b0, i_r};
  assign map_val       = map_vq ? map_q : 16'd0;
  assign frame_wipe    = cmd.frame_clr || (cmd.res_fetch && fetch_last);

  always_comb begin
    stat               = '0;
    stat.cmd           = in_r.cmd;
    stat.pending       = pending_r;
    stat.rx_room       = (count_r < FRAME_LIM);
    stat.short_frame   = (count_r < mbrs_pkg::MIN_FRAME);
    stat.crc_bad       = (crc_r != 16'd0);
    stat.host_in_range = host_in_range;
    stat.addr_match    = (b0_r == slave_r);
    stat.func          = func_r;
    stat.qty_bad       = (qty_r == 16'd0) || (qty_r > mbrs_pkg::QTY_MAX);
    stat.single_bad    = (addr_r >= {9'd0, mw});
    stat.range_bad     = (addr_r >= {9'd0, mw}) ||
                         (({1'b0, addr_r} + {1'b0, qty_r}) > {10'd0, mw});
    stat.bc_bad        = ({9'd0, b6_r} != {qty_r, 1'b0});
    stat.hdr_done      = (ptr_r == 8'd6);
    stat.bit_last      = (bit_r == 3'd7);
    stat.loop_last     = (({9'd0, i_r} + 16'd1) == qty_r);
    stat.seal_done     = (ptr_r == len_r);
  end

  // ---- frame store
  always_comb begin
    case (cmd.addr_sel)
      mbrs_pkg::SA_COUNT: sa = count_r[mbrs_pkg::STORE_AW-1:0];
      mbrs_pkg::SA_POS:   sa = pos_r;
      default:            sa = ptr_r;
    endcase
    case (cmd.wd_sel)
      mbrs_pkg::WD_RX:       wd = in_r.rx_data;
      mbrs_pkg::WD_EXC_FUNC: wd = func_r + mbrs_pkg::EXC_FLAG;
      mbrs_pkg::WD_EXC_CODE: wd = exc_r;
      mbrs_pkg::WD_QTY2:     wd = {qty_r[6:0], 1'b0};
      mbrs_pkg::WD_MAP_HI:   wd = map_val[15:8];
      mbrs_pkg::WD_MAP_LO:   wd = map_val[7:0];
      mbrs_pkg::WD_CRC_LO:   wd = crc_r[7:0];
      default:               wd = crc_r[15:8];
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.store_we) begin
      store_mem[sa] <= wd;
    end
    if (cmd.store_re) begin
      rd_q <= store_mem[sa];
    end
  end

  // ---- register map, valid bit per word stands for the zero reset
  always_comb begin
    case (cmd.map_wr)
      mbrs_pkg::MW_HOST: begin
        map_wa = in_r.host_index[MAP_AW-1:0];
        map_wd = in_r.host_value;
      end
      mbrs_pkg::MW_SINGLE: begin
        map_wa = addr_r[MAP_AW-1:0];
        map_wd = qty_r;
      end
      default: begin
        map_wa = loop_idx[MAP_AW-1:0];
        map_wd = {hi_r, rd_q};
      end
    endcase
    if (cmd.map_rd == mbrs_pkg::MR_HOST) begin
      map_ra = host_in_range ? in_r.host_index[MAP_AW-1:0] : '0;
    end else begin
      map_ra = loop_idx[MAP_AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.map_wr != mbrs_pkg::MW_NONE) begin
      map_mem[map_wa] <= map_wd;
    end
    if (cmd.map_rd != mbrs_pkg::MR_NONE) begin
      map_q  <= map_mem[map_ra];
      map_vq <= map_valid_r[map_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_valid_r <= '0;
    end else if (cmd.map_wr != mbrs_pkg::MW_NONE) begin
      map_valid_r[map_wa] <= 1'b1;
    end
  end

  // ---- crc, frame count, reply pointers
  always_comb begin
    crc_nxt     = crc_r;
    bit_nxt     = bit_r;
    count_nxt   = count_r;
    pending_nxt = pending_r;
    total_nxt   = total_r;
    pos_nxt     = pos_r;
    if (frame_wipe) begin
      crc_nxt   = mbrs_pkg::CRC_INIT;
      count_nxt = 9'd0;
    end else if (cmd.cnt_inc) begin
      count_nxt = count_r + 9'd1;
    end
    case (cmd.crc_op)
      mbrs_pkg::CRC_SEED:   crc_nxt = mbrs_pkg::CRC_INIT;
      mbrs_pkg::CRC_XOR_RX: begin
        crc_nxt = crc_r ^ {8'd0, in_r.rx_data};
        bit_nxt = 3'd0;
      end
      mbrs_pkg::CRC_XOR_RD: begin
        crc_nxt = crc_r ^ {8'd0, rd_q};
        bit_nxt = 3'd0;
      end
      mbrs_pkg::CRC_STEP: begin
        crc_nxt = crc_r[0] ? ((crc_r >> 1) ^ mbrs_pkg::CRC_POLY_REFL) : (crc_r >> 1);
        bit_nxt = bit_r + 3'd1;
      end
      default: ;
    endcase
    if (cmd.reply_start) begin
      pending_nxt = 1'b1;
      total_nxt   = reply_len;
      pos_nxt     = 8'd0;
    end else if (cmd.res_fetch) begin
      if (fetch_last) begin
        pending_nxt = 1'b0;
        pos_nxt     = 8'd0;
      end else begin
        pos_nxt = pos_r + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r     <= mbrs_pkg::CRC_INIT;
      bit_r     <= 3'd0;
      count_r   <= 9'd0;
      pending_r <= 1'b0;
      total_r   <= 8'd0;
      pos_r     <= 8'd0;
      slave_r   <= mbrs_pkg::SLAVE_ADDR_RST;
      mapw_r    <= mbrs_pkg::MAP_WORDS_RST;
    end else begin
      crc_r     <= crc_nxt;
      bit_r     <= bit_nxt;
      count_r   <= count_nxt;
      pending_r <= pending_nxt;
      total_r   <= total_nxt;
      pos_r     <= pos_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          mbrs_pkg::CFG_SLAVE_ADDR: slave_r <= cfg_data;
          mbrs_pkg::CFG_MAP_WORDS:  mapw_r  <= cfg_data[6:0];
          default: ;
        endcase
      end
    end
  end

  // ---- working registers of the serve sequence
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      in_r <= in_data;
    end
    case (cmd.ptr_op)
      mbrs_pkg::PTR_INC: ptr_r <= ptr_r + 8'd1;
      mbrs_pkg::PTR_LD:  ptr_r <= cmd.ptr_val;
      default: ;
    endcase
    case (cmd.len_sel)
      mbrs_pkg::LEN_EXC:   len_r <= 8'd3;
      mbrs_pkg::LEN_WRITE: len_r <= 8'd6;
      mbrs_pkg::LEN_READ:  len_r <= {qty_r[6:0], 1'b0} + 8'd3;
      default: ;
    endcase
    if (cmd.i_clr) begin
      i_r <= 7'd0;
    end else if (cmd.i_inc) begin
      i_r <= i_r + 7'd1;
    end
    if (cmd.exc_ld) begin
      exc_r <= cmd.exc_code;
    end
    if (cmd.hi_cap) begin
      hi_r <= rd_q;
    end
    if (cmd.hdr_cap) begin
      case (ptr_r[2:0])
        3'd0:    b0_r          <= rd_q;
        3'd1:    func_r        <= rd_q;
        3'd2:    addr_r[15:8]  <= rd_q;
        3'd3:    addr_r[7:0]   <= rd_q;
        3'd4:    qty_r[15:8]   <= rd_q;
        3'd5:    qty_r[7:0]    <= rd_q;
        3'd6:    b6_r          <= rd_q;
        default: ;
      endcase
    end
    res_r <= res_nxt;
  end

  // ---- result register
  always_comb begin
    res_nxt = res_r;
    if (cmd.res_clr) begin
      res_nxt = '0;
    end
    if (cmd.status_ld) begin
      res_nxt.frame_status = cmd.status;
    end
    if (cmd.reply_start) begin
      res_nxt.frame_status = mbrs_pkg::ST_READY;
      res_nxt.reply_length = reply_len;
    end
    if (cmd.res_fetch) begin
      res_nxt.tx_valid = 1'b1;
      res_nxt.tx_byte  = rd_q;
      res_nxt.tx_last  = fetch_last;
    end
    if (cmd.res_host) begin
      res_nxt.host_read_value = host_in_range ? map_val : 16'd0;
    end
  end

  assign out_data = res_r;

endmodule

`default_nettype wire

[rtl/core/modbus_rtu_register_slave.sv]
// ----------------------------------------------------------------------------
// modbus_rtu_register_slave
// Modbus RTU slave serving a 16-bit register map (functions 3, 4, 6, 16)
//
// channel   ports                          transfer
// input     start, busy, in_data           start high while busy low
// result    out_valid, out_data            one-cycle strobe, no back-pressure
// config    cfg_valid, cfg_ready, cfg_*    cfg_valid and cfg_ready high
//
// every command gives exactly one result; the block takes one command at a time
// rx byte: a stored byte runs through the 8-step bitwise crc before its result
// fetch, host read: a read step first; host write, ignored: straight to result
// frame end: longest for the longest read reply, set by the header reads,
// the one-word register copy loop and the bitwise crc over each reply byte
// synchronous reset clears the frame state and the register map at once
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_rtu_register_slave #(
  parameter int FRAME_BYTES = mbrs_pkg::FRAME_BYTES_DEF,
  parameter int REG_WORDS   = mbrs_pkg::REG_WORDS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  mbrs_pkg::in_item_t                in_data,
  output logic                              out_valid,
  output mbrs_pkg::out_item_t               out_data,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [mbrs_pkg::CFG_IW-1:0]  cfg_index,
  input  wire logic [7:0]                   cfg_data
);

`include "modbus_rtu_register_slave_defines.svh"

  mbrs_pkg::ctrl_cmd_t ctrl_cmd;
  mbrs_pkg::dp_stat_t  dp_stat;

  assign cfg_ready = 1'b1;

  mbrs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (dp_stat),
    .cmd       (ctrl_cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  mbrs_dp #(
    .FRAME_BYTES (FRAME_BYTES),
    .REG_WORDS   (REG_WORDS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (ctrl_cmd),
    .stat      (dp_stat),
    .out_data  (out_data)
  );

  // accepted command keeps the block busy until its result
  `MBRS_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  // after each result the block is ready again
  `MBRS_ASSERT_NEXT(a_result_idle, clk, rst_n, out_valid, !busy && !out_valid)
  // last-byte flag only rides on a real reply byte
  `MBRS_ASSERT_NOW(a_last_valid, clk, rst_n, out_valid && out_data.tx_last, out_data.tx_valid)
  // a prepared reply always carries at least address, function and crc
  `MBRS_ASSERT_NOW(a_reply_len, clk, rst_n, out_valid && (out_data.frame_status == mbrs_pkg::ST_READY), out_data.reply_length >= 8'd5)

endmodule

`default_nettype wire

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the modbus rtu register slave: request frames with
// good and broken crc, every function and exception path, host register
// access and config changes, results checked against fixed values or an in-bench model
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mbrs_pkg::*;

  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;
  localparam longint     CYCLE_LIMIT  = 1000000;

  logic            clk;
  logic            rst_n;
  logic            start;
  logic            busy;
  in_item_t        in_data;
  logic            out_valid;
  out_item_t       out_data;
  logic            cfg_valid;
  logic            cfg_ready;
  logic [CFG_IW-1:0] cfg_index;
  logic [7:0]      cfg_data;

  modbus_rtu_register_slave dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // slave state as the bench sees it
  logic [7:0]  frame_mem [STORE_DEPTH];
  int unsigned rx_count;
  logic [15:0] reg_file [REG_WORDS_DEF];
  bit          reply_busy;
  int unsigned reply_len;
  int unsigned reply_ptr;
  logic [15:0] rx_crc;
  logic [7:0]  station;
  logic [6:0]  map_size;

  out_item_t   pending_res [$];
  int          errors;
  int          items_sent;
  int          idle_pct;
  longint      cycles;

  typedef struct packed {
    in_item_t  it;
    out_item_t want;
  } single_vec_t;

  typedef struct {
    logic [7:0]  sa;
    logic [7:0]  fn;
    logic [15:0] addr;
    logic [15:0] qty;
    logic [7:0]  bc;
    int          ndata;
    int          cut;
    bit          bad;
  } frame_vec_t;

  single_vec_t single_vecs [9];
  frame_vec_t  frame_vecs [16];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [15:0] crc_update(logic [15:0] c, logic [7:0] b);
    c = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
    return c;
  endfunction

  function automatic int unsigned append_crc(int unsigned len);
    logic [15:0] c;
    c = CRC_INIT;
    for (int unsigned i = 0; i < len; i++) c = crc_update(c, frame_mem[i & 255]);
    frame_mem[len & 255]       = c[7:0];
    frame_mem[(len + 1) & 255] = c[15:8];
    return len + 2;
  endfunction

  function automatic int unsigned exception_reply(logic [7:0] fn, logic [7:0] code);
    frame_mem[1] = fn + EXC_FLAG;
    frame_mem[2] = code;
    return append_crc(3);
  endfunction

  function automatic int unsigned serve_request();
    logic [7:0]  fn;
    int unsigned a, q, mw;
    logic [15:0] v;
    fn = frame_mem[1];
    a  = {frame_mem[2], frame_mem[3]};
    q  = {frame_mem[4], frame_mem[5]};
    mw = (map_size > REG_WORDS_DEF) ? REG_WORDS_DEF : map_size;
    if (fn == FN_READ_HOLD || fn == FN_READ_INPUT) begin
      if (q < 1 || q > QTY_MAX) return exception_reply(fn, EXC_VALUE);
      if (a >= mw || a + q > mw) return exception_reply(fn, EXC_ADDRESS);
      frame_mem[2] = 8'(q * 2);
      for (int unsigned i = 0; i < q; i++) begin
        v = reg_file[a + i];
        frame_mem[(3 + 2 * i) & 255] = v[15:8];
        frame_mem[(4 + 2 * i) & 255] = v[7:0];
      end
      return append_crc(3 + 2 * q);
    end else if (fn == FN_WRITE_ONE) begin
      if (a >= mw) return exception_reply(fn, EXC_ADDRESS);
      reg_file[a] = q[15:0];
      return append_crc(6);
    end else if (fn == FN_WRITE_MANY) begin
      if (q < 1 || q > QTY_MAX || frame_mem[6] != q * 2)
        return exception_reply(fn, EXC_VALUE);
      if (a >= mw || a + q > mw) return exception_reply(fn, EXC_ADDRESS);
      for (int unsigned i = 0; i < q; i++)
        reg_file[a + i] = {frame_mem[(7 + 2 * i) & 255], frame_mem[(8 + 2 * i) & 255]};
      return append_crc(6);
    end
    return exception_reply(fn, EXC_FUNCTION);
  endfunction

  // advances the slave state by one command and returns its result
  function automatic out_item_t slave_step(in_item_t it);
    out_item_t r;
    r = '0;
    case (it.cmd)
      CMD_RX: begin
        if (!reply_busy && rx_count < FRAME_BYTES_DEF) begin
          frame_mem[rx_count & 255] = it.rx_data;
          rx_count++;
          rx_crc = crc_update(rx_crc, it.rx_data);
        end
      end
      CMD_END: begin
        if (!reply_busy) begin
          if (rx_count < 4) r.frame_status = ST_SHORT;
          else if (rx_crc != 16'h0000) r.frame_status = ST_BAD_CRC;
          else if (frame_mem[0] != station) r.frame_status = ST_OTHER_ADDR;
          else begin
            reply_len  = serve_request();
            reply_ptr  = 0;
            reply_busy = 1'b1;
            r.frame_status = ST_READY;
            r.reply_length = reply_len[7:0];
          end
          rx_count = 0;
          rx_crc   = CRC_INIT;
        end
      end
      CMD_FETCH: begin
        if (reply_busy) begin
          r.tx_valid = 1'b1;
          r.tx_byte  = frame_mem[reply_ptr & 255];
          reply_ptr++;
          if (reply_ptr >= reply_len) begin
            r.tx_last  = 1'b1;
            reply_busy = 1'b0;
            reply_ptr  = 0;
            rx_count   = 0;
            rx_crc     = CRC_INIT;
          end
        end
      end
      CMD_HOST_RD: if (it.host_index < REG_WORDS_DEF) r.host_read_value = reg_file[it.host_index];
      CMD_HOST_WR: if (it.host_index < REG_WORDS_DEF) reg_file[it.host_index] = it.host_value;
      default: ;
    endcase
    return r;
  endfunction

  function automatic in_item_t rand_cmd(logic [2:0] c);
    in_item_t it;
    it.cmd        = c;
    it.rx_data    = 8'($urandom);
    it.host_index = 7'($urandom);
    it.host_value = 16'($urandom);
    return it;
  endfunction

  task automatic send(in_item_t it, bit typed = 1'b0, out_item_t want = '0);
    int gap;
    out_item_t p;
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start   <= 1'b1;
    in_data <= it;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    p = slave_step(it);
    pending_res.push_back(typed ? want : p);
    items_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IW-1:0] idx, logic [7:0] d);
    drain();
    repeat (20) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    if (idx == CFG_SLAVE_ADDR) station = d;
    else if (idx == CFG_MAP_WORDS) map_size = d[6:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // sends one request frame and the frame end, then fetches the whole reply if one is prepared
  task automatic run_frame(frame_vec_t f);
    logic [7:0]  b [$];
    logic [15:0] c;
    in_item_t    it;
    b = {f.sa, f.fn, f.addr[15:8], f.addr[7:0], f.qty[15:8], f.qty[7:0]};
    if (f.fn == FN_WRITE_MANY) begin
      b.push_back(f.bc);
      repeat (f.ndata) b.push_back(8'($urandom));
    end
    c = CRC_INIT;
    foreach (b[i]) c = crc_update(c, b[i]);
    if (f.bad) c = c ^ (16'h1 << $urandom_range(15));
    b.push_back(c[7:0]);
    b.push_back(c[15:8]);
    if (f.cut >= 0) while (b.size() > f.cut) b.delete(b.size() - 1);
    foreach (b[i]) begin
      it = rand_cmd(CMD_RX);
      it.rx_data = b[i];
      send(it);
    end
    send(rand_cmd(CMD_END));
    while (reply_busy) begin
      // rx bytes and frame ends are ignored while a reply is pending
      if ($urandom_range(9) == 0) send(rand_cmd($urandom_range(1) ? CMD_RX : CMD_END));
      send(rand_cmd(CMD_FETCH));
    end
    if ($urandom_range(3) == 0) send(rand_cmd(CMD_FETCH));
  endtask

  task automatic random_step();
    int          k, mw;
    frame_vec_t  f;
    in_item_t    it;
    k  = $urandom_range(99);
    mw = (map_size > REG_WORDS_DEF) ? REG_WORDS_DEF : map_size;
    if (k < 65) begin
      f.sa = ($urandom_range(99) < 90) ? station : 8'($urandom);
      k = $urandom_range(99);
      f.fn = (k < 30) ? FN_READ_HOLD : (k < 45) ? FN_READ_INPUT :
             (k < 65) ? FN_WRITE_ONE : (k < 90) ? FN_WRITE_MANY : 8'($urandom);
      f.addr = ($urandom_range(99) < 85) ? 16'($urandom_range(0, mw + 2)) : 16'($urandom);
      k = $urandom_range(99);
      if (f.fn == FN_WRITE_ONE) f.qty = 16'($urandom);
      else if (k < 85) f.qty = 16'($urandom_range(0, 8));
      else if (k < 95) f.qty = 16'($urandom_range(0, 130));
      else f.qty = 16'($urandom);
      f.bc    = ($urandom_range(99) < 90) ? 8'(f.qty * 2) : 8'($urandom_range(0, 20));
      f.ndata = (f.bc <= 40) ? f.bc : $urandom_range(0, 20);
      f.cut   = ($urandom_range(99) < 95) ? -1 : $urandom_range(0, 8);
      f.bad   = ($urandom_range(99) < 4);
      run_frame(f);
    end else if (k < 75) begin
      // broken sequence: a few loose bytes then frame end
      repeat ($urandom_range(0, 10)) send(rand_cmd(CMD_RX));
      send(rand_cmd(CMD_END));
    end else if (k < 85) begin
      send(rand_cmd(CMD_HOST_WR));
    end else if (k < 93) begin
      it = rand_cmd(CMD_HOST_RD);
      if ($urandom_range(1)) it.host_index = 7'($urandom_range(0, REG_WORDS_DEF - 1));
      send(it);
    end else if (k < 97) begin
      send(rand_cmd(CMD_FETCH));
    end else begin
      send(rand_cmd(3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI))));
    end
  endtask

  task automatic report(string field, int unsigned want, int unsigned got);
    $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, field, want, got);
    errors++;
  endtask

  always @(posedge clk) begin : result_check
    out_item_t e;
    if (rst_n && out_valid) begin
      if (pending_res.size() == 0) begin
        $display("%0t: result with nothing expected, expected none actual %p",
                 $time, out_data);
        errors++;
      end else begin
        e = pending_res.pop_front();
        if (out_data.frame_status !== e.frame_status)
          report("frame_status", e.frame_status, out_data.frame_status);
        if (out_data.reply_length !== e.reply_length)
          report("reply_length", e.reply_length, out_data.reply_length);
        if (out_data.tx_valid !== e.tx_valid) report("tx_valid", e.tx_valid, out_data.tx_valid);
        if (out_data.tx_byte !== e.tx_byte) report("tx_byte", e.tx_byte, out_data.tx_byte);
        if (out_data.tx_last !== e.tx_last) report("tx_last", e.tx_last, out_data.tx_last);
        if (out_data.host_read_value !== e.host_read_value)
          report("host_read_value", e.host_read_value, out_data.host_read_value);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin
    int target;
    int pct_list [4];
    in_item_t fill;
    start     = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    rst_n     = 1'b0;
    errors    = 0;
    items_sent = 0;
    cycles    = 0;
    idle_pct  = 0;
    foreach (frame_mem[i]) frame_mem[i] = 8'h00;
    foreach (reg_file[i]) reg_file[i] = 16'h0000;
    rx_count   = 0;
    rx_crc     = CRC_INIT;
    reply_busy = 1'b0;
    reply_len  = 0;
    reply_ptr  = 0;
    station    = SLAVE_ADDR_RST;
    map_size   = MAP_WORDS_RST;
    pct_list   = '{0, 76, 29, 76};

    single_vecs = '{
      '{'{CMD_HOST_RD, 8'h00, 7'd0, 16'h0000}, '0},
      '{'{CMD_HOST_RD, 8'hFF, 7'd127, 16'hFFFF}, '0},
      '{'{CMD_HOST_WR, 8'h00, 7'd127, 16'hFFFF}, '0},
      '{'{CMD_HOST_WR, 8'hFF, 7'd63, 16'hFFFF}, '0},
      '{'{CMD_HOST_RD, 8'h00, 7'd63, 16'h0000}, '{ST_NONE, 8'd0, 1'b0, 8'd0, 1'b0, 16'hFFFF}},
      '{'{CMD_FETCH, 8'h00, 7'd0, 16'h0000}, '0},
      '{'{CMD_END, 8'h00, 7'd0, 16'h0000}, '{ST_SHORT, 8'd0, 1'b0, 8'd0, 1'b0, 16'h0000}},
      '{'{CMD_SPARE_LO, 8'hFF, 7'd127, 16'hFFFF}, '0},
      '{'{CMD_SPARE_HI, 8'hA5, 7'd5, 16'h5A5A}, '0}
    };
    frame_vecs = '{
      '{8'd1, FN_READ_HOLD,  16'd0,     16'd1,     8'd0, 0, -1, 1'b0},
      '{8'd1, FN_READ_INPUT, 16'd0,     16'd64,    8'd0, 0, -1, 1'b0},
      '{8'd1, FN_READ_HOLD,  16'd0,     16'd0,     8'd0, 0, -1, 1'b0},
      '{8'd1, FN_READ_HOLD,  16'd0,     16'd126,   8'd0, 0, -1, 1'b0},
      '{8'd1, FN_READ_HOLD,  16'd63,    16'd2,     8'd0, 0, -1, 1'b0},
      '{8'd1, FN_READ_HOLD,  16'hFFFF,  16'd1,     8'd0, 0, -1, 1'b0},
      '{8'd1, FN_WRITE_ONE,  16'd5,     16'hFFFF,  8'd0, 0, -1, 1'b0},
      '{8'd1, FN_WRITE_ONE,  16'd64,    16'd1,     8'd0, 0, -1, 1'b0},
      '{8'd1, FN_WRITE_MANY, 16'd10,    16'd3,     8'd6, 6, -1, 1'b0},
      '{8'd1, FN_WRITE_MANY, 16'd10,    16'd3,     8'd5, 5, -1, 1'b0},
      '{8'd1, FN_WRITE_MANY, 16'd62,    16'd3,     8'd6, 6, -1, 1'b0},
      '{8'd1, 8'hFF,         16'd0,     16'd1,     8'd0, 0, -1, 1'b0},
      '{8'd1, FN_READ_HOLD,  16'd0,     16'd2,     8'd0, 0, -1, 1'b1},
      '{8'd0, FN_READ_HOLD,  16'd0,     16'd1,     8'd0, 0, -1, 1'b0},
      '{8'd1, FN_READ_HOLD,  16'd0,     16'd1,     8'd0, 0,  3, 1'b0},
      '{8'd1, FN_READ_HOLD,  16'd4,     16'd8,     8'd0, 0, -1, 1'b0}
    };

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // overfill the frame store first: every entry gets written and the
    // bytes past the buffer are dropped
    repeat (FRAME_BYTES_DEF + 4) begin
      fill = rand_cmd(CMD_RX);
      send(fill);
    end
    send(rand_cmd(CMD_END));

    foreach (single_vecs[i])
      send(single_vecs[i].it, single_vecs[i].want != '0 ||
           single_vecs[i].it.cmd inside {CMD_HOST_RD, CMD_FETCH, CMD_END},
           single_vecs[i].want);
    foreach (frame_vecs[i]) run_frame(frame_vecs[i]);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin cfg_write(CFG_SLAVE_ADDR, 8'd247); cfg_write(CFG_MAP_WORDS, 8'd127); end
        1: begin cfg_write(CFG_SLAVE_ADDR, 8'd1);   cfg_write(CFG_MAP_WORDS, 8'd1);   end
        2: begin
          cfg_write(CFG_SLAVE_ADDR, 8'($urandom_range(2, 246)));
          cfg_write(CFG_MAP_WORDS, 8'd0);
        end
        default: begin
          cfg_write(CFG_SLAVE_ADDR, 8'($urandom_range(1, 247)));
          cfg_write(CFG_MAP_WORDS, 8'($urandom_range(1, 127)));
        end
      endcase
      idle_pct = pct_list[ph];
      target = items_sent + 125;
      while (items_sent < target) random_step();
    end

    drain();
    repeat (30) @(posedge clk);
    if (errors == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
+incdir+rtl/core
rtl/core/mbrs_pkg.sv
rtl/core/mbrs_ctrl.sv
rtl/core/mbrs_dp.sv
rtl/core/modbus_rtu_register_slave.sv
sim/tb_top.sv
